[hw/rtl/fbfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_pkg
// Shared types and constants for the first/best fit block allocator.
// ----------------------------------------------------------------------------
package fbfa_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int IDX_BITS = 4;
  localparam int AMT_BITS = 16;
  localparam int CNT_BITS = 5;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_BEST  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_COUNT = 1'b1;

  localparam logic [CNT_BITS-1:0] BLOCK_COUNT_RST = 5'd16;

  typedef struct packed {
    logic                operation;
    logic [IDX_BITS-1:0] block_index;
    logic [AMT_BITS-1:0] amount;
  } in_t;

  typedef struct packed {
    logic                granted;
    logic [IDX_BITS-1:0] chosen_block;
    logic [AMT_BITS-1:0] remaining_after;
  } out_t;

  typedef struct packed {
    logic vld;
    logic found;
  } scan_ctl_t;

endpackage

[hw/rtl/fbfa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfa_cell
// One block entry: holds its remaining size and updates the passing search.
// ----------------------------------------------------------------------------
module fbfa_cell #(
  parameter int CELL_IDX  = 0,
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = fbfa_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fit_mode,
  input  logic [fbfa_pkg::CNT_BITS-1:0]   block_count,
  input  logic                            wr_en,
  input  logic [IDX_W-1:0]                wr_idx,
  input  logic [SIZE_BITS-1:0]            wr_data,
  input  fbfa_pkg::scan_ctl_t             i_ctl,
  input  logic [IDX_W-1:0]                i_idx,
  input  logic [SIZE_BITS-1:0]            i_size,
  input  logic [SIZE_BITS-1:0]            i_req,
  output fbfa_pkg::scan_ctl_t             o_ctl,
  output logic [IDX_W-1:0]                o_idx,
  output logic [SIZE_BITS-1:0]            o_size,
  output logic [SIZE_BITS-1:0]            o_req
);

  logic [SIZE_BITS-1:0] size_r;
  logic [SIZE_BITS-1:0] size_nxt;
  fbfa_pkg::scan_ctl_t  ctl_r;
  fbfa_pkg::scan_ctl_t  ctl_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [SIZE_BITS-1:0] best_r;
  logic [SIZE_BITS-1:0] req_r;
  logic                 in_use;
  logic                 fits;
  logic                 take;

  assign in_use = (32'(block_count) > 32'(CELL_IDX));
  assign fits   = i_ctl.vld && in_use && (size_r >= i_req);
  assign take   = fits && (!i_ctl.found ||
                           ((fit_mode == fbfa_pkg::MODE_BEST) && (size_r < i_size)));

  assign size_nxt = (wr_en && (wr_idx == IDX_W'(CELL_IDX))) ? wr_data : size_r;

  always_comb begin
    ctl_nxt.vld   = i_ctl.vld;
    ctl_nxt.found = i_ctl.found | take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      ctl_r  <= '0;
    end else begin
      size_r <= size_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= take ? IDX_W'(CELL_IDX) : i_idx;
    best_r <= take ? size_r : i_size;
    req_r  <= i_req;
  end

  assign o_ctl  = ctl_r;
  assign o_idx  = idx_r;
  assign o_size = best_r;
  assign o_req  = req_r;

endmodule

[hw/rtl/first_best_fit_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_best_fit_block_allocator
// First-fit / best-fit allocator over a chain of block cells.
// ----------------------------------------------------------------------------
// loads: one per cycle while no allocation is in progress, no result
// allocation: result registered at the chain end, then into the output
//   register; no accept until then; the search walks one cell per cycle
// reset: synchronous, all block sizes zero, first fit, block count 16
module first_best_fit_block_allocator #(
  parameter int MAX_BLOCKS = fbfa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fbfa_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fbfa_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fbfa_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [fbfa_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int IDX_W = ($clog2(MAX_BLOCKS) > fbfa_pkg::IDX_BITS) ?
                         $clog2(MAX_BLOCKS) : fbfa_pkg::IDX_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic                            mode_r;
  logic [fbfa_pkg::CNT_BITS-1:0]   count_r;
  fbfa_pkg::out_t                  res_r, res_nxt;
  fbfa_pkg::out_t                  out_r;
  logic                            out_valid_r, out_valid_nxt;

  fbfa_pkg::scan_ctl_t             ctl_a   [0:MAX_BLOCKS];
  logic [IDX_W-1:0]                idx_a   [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0]            size_a  [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0]            req_a   [0:MAX_BLOCKS];

  fbfa_pkg::scan_ctl_t             launch_r, launch_nxt;
  logic [SIZE_BITS-1:0]            req_r;

  logic                            accept;
  logic                            final_vld;
  logic [SIZE_BITS-1:0]            diff;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_idx;
  logic [SIZE_BITS-1:0]            wr_data;
  logic                            out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign final_vld = (state_r == ST_SCAN) && ctl_a[MAX_BLOCKS].vld;
  assign diff      = size_a[MAX_BLOCKS] - req_a[MAX_BLOCKS];

  always_comb begin
    launch_nxt.vld   = accept && (in_data.operation == fbfa_pkg::OP_ALLOC);
    launch_nxt.found = 1'b0;
  end

  always_comb begin
    if (final_vld) begin
      wr_en   = ctl_a[MAX_BLOCKS].found;
      wr_idx  = idx_a[MAX_BLOCKS];
      wr_data = diff;
    end else begin
      wr_en   = accept && (in_data.operation == fbfa_pkg::OP_LOAD);
      wr_idx  = IDX_W'(in_data.block_index);
      wr_data = SIZE_BITS'(in_data.amount);
    end
  end

  always_comb begin
    res_nxt       = res_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (launch_nxt.vld) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (final_vld) begin
          state_nxt = ST_DONE;
          if (ctl_a[MAX_BLOCKS].found) begin
            res_nxt.granted         = 1'b1;
            res_nxt.chosen_block    = fbfa_pkg::IDX_BITS'(idx_a[MAX_BLOCKS]);
            res_nxt.remaining_after = fbfa_pkg::AMT_BITS'(diff);
          end else begin
            res_nxt = '0;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= fbfa_pkg::MODE_FIRST;
      count_r     <= fbfa_pkg::BLOCK_COUNT_RST;
      out_valid_r <= 1'b0;
      launch_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      launch_r    <= launch_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          fbfa_pkg::CFG_FIT_MODE:    mode_r  <= cfg_wdata[0];
          fbfa_pkg::CFG_BLOCK_COUNT: count_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      req_r <= SIZE_BITS'(in_data.amount);
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_r <= res_r;
    end
  end

  assign ctl_a[0]  = launch_r;
  assign idx_a[0]  = '0;
  assign size_a[0] = '0;
  assign req_a[0]  = req_r;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fbfa_cell #(
      .CELL_IDX  (g),
      .IDX_W     (IDX_W),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .fit_mode    (mode_r),
      .block_count (count_r),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .i_ctl       (ctl_a[g]),
      .i_idx       (idx_a[g]),
      .i_size      (size_a[g]),
      .i_req       (req_a[g]),
      .o_ctl       (ctl_a[g+1]),
      .o_idx       (idx_a[g+1]),
      .o_size      (size_a[g+1]),
      .o_req       (req_a[g+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and allocate transactions into the first/best fit allocator,
// predicts each grant from a private copy of the free-size table, and checks
// every result in order while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NBLK  = fbfa_pkg::MAX_BLOCKS_DEF;
  localparam int CFG_W = fbfa_pkg::CFG_DATA_BITS;

  class fit_tracker;
    logic [fbfa_pkg::AMT_BITS-1:0] sizes [NBLK];
    logic                          mode;
    logic [fbfa_pkg::CNT_BITS-1:0] count;
    fbfa_pkg::out_t                expected_grants [$];
    int                            errors;

    function new();
      for (int k = 0; k < NBLK; k++) sizes[k] = '0;
      mode   = fbfa_pkg::MODE_FIRST;
      count  = fbfa_pkg::BLOCK_COUNT_RST;
      errors = 0;
    endfunction

    function void set_register(logic [fbfa_pkg::CFG_IDX_BITS-1:0] idx,
                               logic [fbfa_pkg::CFG_DATA_BITS-1:0] val);
      if (idx == fbfa_pkg::CFG_FIT_MODE) mode = val[0];
      else count = val;
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    // accepted input transaction: update the table, queue the grant if any
    function void take_request(fbfa_pkg::in_t item);
      int             limit;
      int             pick;
      bit             found;
      fbfa_pkg::out_t grant;
      if (item.operation == fbfa_pkg::OP_LOAD) begin
        sizes[item.block_index] = item.amount;
        return;
      end
      limit = (count > NBLK) ? NBLK : count;
      found = 1'b0;
      pick  = 0;
      for (int j = 0; j < limit; j++) begin
        if (sizes[j] >= item.amount) begin
          if (mode == fbfa_pkg::MODE_FIRST) begin
            if (!found) begin
              pick  = j;
              found = 1'b1;
            end
          end else if (!found || sizes[j] < sizes[pick]) begin
            pick  = j;
            found = 1'b1;
          end
        end
      end
      grant = '0;
      if (found) begin
        sizes[pick]           = sizes[pick] - item.amount;
        grant.granted         = 1'b1;
        grant.chosen_block    = pick[fbfa_pkg::IDX_BITS-1:0];
        grant.remaining_after = sizes[pick];
      end
      expected_grants.push_back(grant);
    endfunction

    function void check_grant(fbfa_pkg::out_t got);
      fbfa_pkg::out_t want;
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        errors++;
        return;
      end
      want = expected_grants.pop_front();
      if (got.granted !== want.granted) begin
        $display("%0t: granted expected %0d actual %0d", $time,
                 want.granted, got.granted);
        errors++;
      end
      if (got.chosen_block !== want.chosen_block) begin
        $display("%0t: chosen_block expected %0d actual %0d", $time,
                 want.chosen_block, got.chosen_block);
        errors++;
      end
      if (got.remaining_after !== want.remaining_after) begin
        $display("%0t: remaining_after expected %0d actual %0d", $time,
                 want.remaining_after, got.remaining_after);
        errors++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  fbfa_pkg::in_t                       in_data;
  logic                                out_valid;
  logic                                out_ready;
  fbfa_pkg::out_t                      out_data;
  logic                                cfg_we;
  logic [fbfa_pkg::CFG_IDX_BITS-1:0]   cfg_idx;
  logic [fbfa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  fit_tracker tracker = new();
  bit         idle_on;
  int         hold_cycles;

  first_best_fit_block_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic fbfa_pkg::in_t pack_item(logic op, int idx, int amt);
    fbfa_pkg::in_t item;
    item.operation   = op;
    item.block_index = idx[fbfa_pkg::IDX_BITS-1:0];
    item.amount      = amt[fbfa_pkg::AMT_BITS-1:0];
    return item;
  endfunction

  // load sizes: partly coarse values so best fit sees ties
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 65535);
    if (r < 60) return $urandom_range(0, 15) * 16;
    if (r < 70) return (r < 65) ? 0 : 65535;
    return $urandom_range(0, 1000);
  endfunction

  // requests: exact or near fits of table sizes, small, wide, extremes
  function automatic int pick_request();
    int r;
    int sz;
    int d;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      sz = int'(tracker.sizes[$urandom_range(0, NBLK - 1)]);
      d  = $urandom_range(0, 2);
      return (sz >= d) ? sz - d : sz;
    end
    if (r < 70) return $urandom_range(0, 300);
    if (r < 85) return $urandom_range(0, 65535);
    return (r < 92) ? 0 : 65535;
  endfunction

  task automatic send_op(input fbfa_pkg::in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_request(item);
  endtask

  // let every queued grant come back and the search go quiet
  task automatic settle();
    int w;
    @(negedge clk);
    in_valid = 1'b0;
    for (w = 0; w < 20000 && tracker.pending() > 0; w++) @(posedge clk);
    repeat (NBLK + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbfa_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [fbfa_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_register(idx, val);
  endtask

  task automatic run_phase(input int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 30)
        send_op(pack_item(fbfa_pkg::OP_LOAD, $urandom_range(0, NBLK - 1),
                          pick_size()));
      else
        send_op(pack_item(fbfa_pkg::OP_ALLOC, $urandom_range(0, NBLK - 1),
                          pick_request()));
    end
  endtask

  // result side
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = pick_gap();
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      tracker.check_grant(out_data);
  end

  initial begin
    int ph;
    int r;
    int cnt;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    idle_on     = 1'b1;
    hold_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table: zero-size request fits block 0, anything else refused
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 0));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 15, 1));
    send_op(pack_item(fbfa_pkg::OP_LOAD, 0, 100));
    send_op(pack_item(fbfa_pkg::OP_LOAD, 1, 50));
    send_op(pack_item(fbfa_pkg::OP_LOAD, 2, 65535));
    send_op(pack_item(fbfa_pkg::OP_LOAD, 3, 50));
    send_op(pack_item(fbfa_pkg::OP_LOAD, 15, 30));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 40));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 65535));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 65535));

    settle();
    write_reg(fbfa_pkg::CFG_FIT_MODE, CFG_W'(fbfa_pkg::MODE_BEST));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 45));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 20));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 0));

    // block count extremes: one block, none, saturated above the table size
    settle();
    write_reg(fbfa_pkg::CFG_BLOCK_COUNT, CFG_W'(1));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 60));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 1));
    settle();
    write_reg(fbfa_pkg::CFG_BLOCK_COUNT, CFG_W'(0));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 0));
    send_op(pack_item(fbfa_pkg::OP_LOAD, 14, 65535));
    settle();
    write_reg(fbfa_pkg::CFG_BLOCK_COUNT, CFG_W'(31));
    send_op(pack_item(fbfa_pkg::OP_LOAD, 15, 65535));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 65535));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 65535));
    send_op(pack_item(fbfa_pkg::OP_ALLOC, 0, 0));

    for (ph = 0; ph < 20; ph++) begin
      settle();
      write_reg(fbfa_pkg::CFG_FIT_MODE, CFG_W'($urandom_range(0, 1)));
      r = $urandom_range(0, 9);
      if (r < 5) cnt = NBLK;
      else if (r < 8) cnt = $urandom_range(1, NBLK);
      else if (r < 9) cnt = 0;
      else cnt = $urandom_range(NBLK + 1, 31);
      write_reg(fbfa_pkg::CFG_BLOCK_COUNT, CFG_W'(cnt));
      idle_on = (ph % 3 != 2);
      // long receiver hold while requests keep coming
      if (ph == 2) hold_cycles = 300;
      run_phase(60);
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
